// ===== rtl/dccf_pkg.sv =====
// ----------------------------------------------------------------------------
// dccf_pkg: shared types and constants for the DDS channel command framer
// Command and output beat layouts, register addresses, limits and the fixed
// reciprocal constants used for the tuning-word and phase-word scaling.
// ----------------------------------------------------------------------------
package dccf_pkg;

  localparam int ValueW   = 28;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int MaxBeats = 7;
  localparam int BeatCntW = $clog2(MaxBeats + 1);
  localparam int WordW    = 16;

  typedef enum logic [1:0] {
    ACT_FREQ  = 2'd0,
    ACT_AMPL  = 2'd1,
    ACT_PHASE = 2'd2
  } act_t;

  localparam logic [CfgIdxW-1:0] CFG_SEL_ZERO = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEL_ONE  = 2'd1;

  localparam logic [ByteW-1:0] SEL_ZERO_RST = 8'h50;
  localparam logic [ByteW-1:0] SEL_ONE_RST  = 8'hA0;

  localparam logic [ByteW-1:0] CSR_ADDR = 8'h00;
  localparam logic [ByteW-1:0] FTW_ADDR = 8'h04;
  localparam logic [ByteW-1:0] POW_ADDR = 8'h05;
  localparam logic [ByteW-1:0] ACR_ADDR = 8'h06;
  localparam logic [ByteW-1:0] AMPL_PAD = 8'h00;

  localparam logic [ValueW-1:0] FREQ_MAX  = 28'd200000000;
  localparam logic [ValueW-1:0] AMPL_MAX  = 28'd1023;
  localparam logic [ValueW-1:0] PHASE_MAX = 28'd360;

  localparam logic [WordW-1:0] AMPL_ENABLE = 16'h1000;
  localparam int AmplW = 10;

  // Beat counts per command and the place of the channel-select byte
  localparam logic [BeatCntW-1:0] FREQ_BEATS  = BeatCntW'(7);
  localparam logic [BeatCntW-1:0] AMPL_BEATS  = BeatCntW'(6);
  localparam logic [BeatCntW-1:0] PHASE_BEATS = BeatCntW'(5);
  localparam logic [BeatCntW-1:0] POS_SEL     = BeatCntW'(1);
  localparam logic [BeatCntW-1:0] CNT_LAST    = BeatCntW'(1);

  // Tuning word = floor(f * 2^32 / SysClkHz), done as f * recip >> FreqShift.
  // The shift is wide enough that the rounded-up reciprocal is exact up to FREQ_MAX.
  localparam longint SysClkHz   = 64'd500000000;
  localparam int     FreqShift  = 49;
  localparam int     FreqWordW  = 32;
  localparam int     FreqRecipW = 53;
  localparam int     FreqLoW    = 27;
  localparam int     FreqHiW    = FreqRecipW - FreqLoW;
  localparam logic [127:0] FreqRecipFull =
    ((128'd1 << (FreqWordW + FreqShift)) / 128'(SysClkHz)) + 128'd1;
  localparam logic [FreqHiW-1:0] FREQ_RECIP_HI = FreqRecipFull[FreqRecipW-1:FreqLoW];
  localparam logic [FreqLoW-1:0] FREQ_RECIP_LO = FreqRecipFull[FreqLoW-1:0];
  localparam int FreqHiProdW = ValueW + FreqHiW;
  localparam int FreqLoProdW = ValueW + FreqLoW;
  localparam int FreqSumW    = ValueW + FreqRecipW;

  // Phase word = floor(p * PhaseNum / PhaseDen), done as p * recip >> PhaseShift
  localparam longint PhaseNum   = 64'd45511111;
  localparam longint PhaseDen   = 64'd1000000;
  localparam int     PhaseShift = 29;
  localparam int     PhaseInW   = 9;
  localparam int     PhaseRecipW = 35;
  localparam logic [127:0] PhaseRecipFull =
    ((128'(PhaseNum) << PhaseShift) / 128'(PhaseDen)) + 128'd1;
  localparam logic [PhaseRecipW-1:0] PHASE_RECIP = PhaseRecipFull[PhaseRecipW-1:0];
  localparam int PhaseProdW = PhaseInW + PhaseRecipW;

  typedef struct packed {
    logic [1:0]        action;
    logic              channel;
    logic [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] spi_byte;
    logic             frame_end;
    logic             last;
  } beat_t;

endpackage

// ===== rtl/dds_channel_command_framer.sv =====
// ----------------------------------------------------------------------------
// DDS channel command framer: one command to two framed register writes, bytewise
// First beat: a taken command passes the stage 1 and 2 registers into the stage 3 line.
// Throughput: one beat per unstalled cycle; 7, 6 or 5 beats for freq/ampl/phase.
// Reset: rst clears pipeline valids and beat count; select words return to defaults.
// ----------------------------------------------------------------------------
module dds_channel_command_framer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  dccf_pkg::cmd_t                  cmd_data,
  output logic                            spi_valid,
  input  logic                            spi_stall,
  output dccf_pkg::beat_t                 spi_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dccf_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dccf_pkg::ByteW-1:0]      cfg_data
);
  import dccf_pkg::*;

  logic [ByteW-1:0] sel_zero;
  logic [ByteW-1:0] sel_one;

  // Stage 1: clamped command
  logic              s1_valid;
  logic [1:0]        s1_action;
  logic              s1_channel;
  logic [ValueW-1:0] s1_value;

  // Stage 2: products
  logic                   s2_valid;
  logic [1:0]             s2_action;
  logic                   s2_channel;
  logic [FreqHiProdW-1:0] s2_freq_hi;
  logic [FreqLoProdW-1:0] s2_freq_lo;
  logic [PhaseProdW-1:0]  s2_phase;
  logic [AmplW-1:0]       s2_ampl;

  // Stage 3: byte shift line
  logic [ByteW-1:0]    sr [MaxBeats];
  logic [BeatCntW-1:0] cnt;
  logic [BeatCntW-1:0] pos;

  logic                   cmd_take;
  logic                   cmd_known;
  logic [ValueW-1:0]      clamp_value;
  logic                   beat_take;
  logic                   s3_free;
  logic                   s2_free;
  logic                   s1_free;
  logic                   s2_adv;
  logic [FreqHiProdW-1:0] freq_hi_prod;
  logic [FreqLoProdW-1:0] freq_lo_prod;
  logic [PhaseProdW-1:0]  phase_prod;
  logic [FreqSumW-1:0]    freq_sum;
  logic [FreqWordW-1:0]   freq_word;
  logic [WordW-1:0]       phase_word;
  logic [WordW-1:0]       ampl_word;
  logic [ByteW-1:0]       sel_byte;
  logic [ByteW-1:0]       load_bytes [MaxBeats];
  logic [BeatCntW-1:0]    load_cnt;

  // ---------------- handshake ----------------
  assign cfg_ready = 1'b1;
  assign spi_valid = (cnt != '0);
  assign beat_take = spi_valid && !spi_stall;
  assign s3_free   = !spi_valid || (beat_take && cnt == CNT_LAST);
  assign s2_free   = !s2_valid || s3_free;
  assign s2_adv    = s2_valid && s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign cmd_stall = !s1_free;
  assign cmd_take  = cmd_valid && !cmd_stall;

  assign cmd_known = (cmd_data.action == ACT_FREQ) || (cmd_data.action == ACT_AMPL) ||
                     (cmd_data.action == ACT_PHASE);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_zero <= SEL_ZERO_RST;
      sel_one  <= SEL_ONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEL_ZERO: sel_zero <= cfg_data;
        CFG_SEL_ONE:  sel_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: saturate ----------------
  always_comb begin
    clamp_value = cmd_data.value;
    unique case (cmd_data.action)
      ACT_FREQ:  if (cmd_data.value > FREQ_MAX)  clamp_value = FREQ_MAX;
      ACT_AMPL:  if (cmd_data.value > AMPL_MAX)  clamp_value = AMPL_MAX;
      ACT_PHASE: if (cmd_data.value > PHASE_MAX) clamp_value = PHASE_MAX;
      default:   clamp_value = cmd_data.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      // drop the unused action code here
      s1_valid <= cmd_take && cmd_known;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_action  <= cmd_data.action;
      s1_channel <= cmd_data.channel;
      s1_value   <= clamp_value;
    end
  end

  // ---------------- stage 2: multiply ----------------
  assign freq_hi_prod = FreqHiProdW'(s1_value) * FreqHiProdW'(FREQ_RECIP_HI);
  assign freq_lo_prod = FreqLoProdW'(s1_value) * FreqLoProdW'(FREQ_RECIP_LO);
  assign phase_prod   = PhaseProdW'(s1_value[PhaseInW-1:0]) * PhaseProdW'(PHASE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_action  <= s1_action;
      s2_channel <= s1_channel;
      s2_freq_hi <= freq_hi_prod;
      s2_freq_lo <= freq_lo_prod;
      s2_phase   <= phase_prod;
      s2_ampl    <= s1_value[AmplW-1:0];
    end
  end

  // ---------------- stage 3: build the frame ----------------
  assign freq_sum   = {s2_freq_hi, {FreqLoW{1'b0}}} + FreqSumW'(s2_freq_lo);
  assign freq_word  = freq_sum[FreqSumW-1 -: FreqWordW];
  assign phase_word = WordW'(s2_phase[PhaseProdW-1:PhaseShift]);
  assign ampl_word  = AMPL_ENABLE | WordW'(s2_ampl);
  assign sel_byte   = s2_channel ? sel_one : sel_zero;

  always_comb begin
    for (int i = 0; i < MaxBeats; i++) begin
      load_bytes[i] = '0;
    end
    load_bytes[0] = CSR_ADDR;
    load_bytes[1] = sel_byte;
    load_cnt      = '0;
    unique case (s2_action)
      ACT_FREQ: begin
        load_bytes[2] = FTW_ADDR;
        load_bytes[3] = freq_word[31:24];
        load_bytes[4] = freq_word[23:16];
        load_bytes[5] = freq_word[15:8];
        load_bytes[6] = freq_word[7:0];
        load_cnt      = FREQ_BEATS;
      end
      ACT_AMPL: begin
        load_bytes[2] = ACR_ADDR;
        load_bytes[3] = AMPL_PAD;
        load_bytes[4] = ampl_word[15:8];
        load_bytes[5] = ampl_word[7:0];
        load_cnt      = AMPL_BEATS;
      end
      ACT_PHASE: begin
        load_bytes[2] = POW_ADDR;
        load_bytes[3] = phase_word[15:8];
        load_bytes[4] = phase_word[7:0];
        load_cnt      = PHASE_BEATS;
      end
      default: load_cnt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
    end else if (s2_adv) begin
      cnt <= load_cnt;
      pos <= '0;
    end else if (beat_take) begin
      cnt <= cnt - BeatCntW'(1);
      pos <= pos + BeatCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      sr <= load_bytes;
    end else if (beat_take) begin
      // advance to the next byte
      for (int i = 0; i < MaxBeats - 1; i++) begin
        sr[i] <= sr[i+1];
      end
      sr[MaxBeats-1] <= '0;
    end
  end

  assign spi_data.spi_byte  = sr[0];
  assign spi_data.frame_end = (pos == POS_SEL) || (cnt == CNT_LAST);
  assign spi_data.last      = (cnt == CNT_LAST);

`ifndef SYNTHESIS
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (spi_valid && spi_data.last) |-> spi_data.frame_end)
    else $error("last beat without chip-select release");

  a_frame_starts_csr: assert property (@(posedge clk) disable iff (rst)
    (spi_valid && !spi_stall && spi_data.last) |=>
      (!spi_valid || spi_data.spi_byte == CSR_ADDR))
    else $error("new command does not open with the select-register address");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (s1_valid && s2_valid))
    else $error("command stalled while the pipeline has room");
`endif

endmodule

// ===== test/dds_channel_command_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_channel_command_framer_tb: self-checking bench for the command framer
// Drives set-frequency, set-amplitude and set-phase commands on both channels.
// Predicts the two framed register writes that each known command produces and
// checks every output beat in order. The sender runs in random bursts and
// the receiver stalls on a pattern of its own, with one long hold-off.
// The channel-select registers are swept between test phases.
// ----------------------------------------------------------------------------
module dds_channel_command_framer_tb;
  import dccf_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_HI = 2'd3;

  localparam longint unsigned DDS_CLK_HZ      = 64'd500_000_000;
  localparam longint unsigned PHASE_RATIO_NUM = 64'd45_511_111;
  localparam longint unsigned PHASE_RATIO_DEN = 64'd1_000_000;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_CADENCE} rx_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd_data = '0;
  logic spi_valid;
  logic spi_stall = 1'b0;
  beat_t spi_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0] cfg_data = '0;

  // Predictor copy of the channel-select registers
  logic [ByteW-1:0] sel_zero = SEL_ZERO_RST;
  logic [ByteW-1:0] sel_one  = SEL_ONE_RST;

  beat_t pending_beats[$];
  int unsigned failures = 0;
  int unsigned burst_left = 0;
  bit allow_gaps = 1'b1;
  logic hold_active = 1'b0;
  event hold_kick;
  rx_mode_t rx_mode = RX_FLOW;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;

  dds_channel_command_framer u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .spi_valid (spi_valid),
    .spi_stall (spi_stall),
    .spi_data  (spi_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void flag_failure(string what);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic void push_beat(logic [ByteW-1:0] b, logic fe, logic lst);
    beat_t bt;
    bt.spi_byte  = b;
    bt.frame_end = fe;
    bt.last      = lst;
    pending_beats.push_back(bt);
  endfunction

  // Queue the beats of both framed writes for one accepted command
  function automatic void predict_frames(cmd_t cmd);
    longint unsigned v;
    longint unsigned word;
    logic [ByteW-1:0] reg_addr;
    logic [ByteW-1:0] payload [4];
    int n_data;
    v = 64'(cmd.value);
    case (cmd.action)
      ACT_FREQ: begin
        if (v > 64'(FREQ_MAX)) v = 64'(FREQ_MAX);
        word = (v << 32) / DDS_CLK_HZ;
        reg_addr = FTW_ADDR;
        payload[0] = word[31:24];
        payload[1] = word[23:16];
        payload[2] = word[15:8];
        payload[3] = word[7:0];
        n_data = 4;
      end
      ACT_AMPL: begin
        if (v > 64'(AMPL_MAX)) v = 64'(AMPL_MAX);
        word = v | 64'(AMPL_ENABLE);
        reg_addr = ACR_ADDR;
        payload[0] = AMPL_PAD;
        payload[1] = word[15:8];
        payload[2] = word[7:0];
        n_data = 3;
      end
      ACT_PHASE: begin
        if (v > 64'(PHASE_MAX)) v = 64'(PHASE_MAX);
        word = (v * PHASE_RATIO_NUM) / PHASE_RATIO_DEN;
        reg_addr = POW_ADDR;
        payload[0] = word[15:8];
        payload[1] = word[7:0];
        n_data = 2;
      end
      default: return;  // unused action: nothing framed
    endcase
    push_beat(CSR_ADDR, 1'b0, 1'b0);
    push_beat(cmd.channel ? sel_one : sel_zero, 1'b1, 1'b0);
    push_beat(reg_addr, 1'b0, 1'b0);
    for (int k = 0; k < n_data; k++) begin
      push_beat(payload[k], k == n_data - 1, k == n_data - 1);
    end
  endfunction

  function automatic cmd_t mk_cmd(logic [1:0] act, logic ch, logic [ValueW-1:0] val);
    cmd_t c;
    c.action  = act;
    c.channel = ch;
    c.value   = val;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    logic [ValueW-1:0] lim;
    int unsigned roll;
    c.channel = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      c.action = ACT_UNUSED;
    end else begin
      case (roll % 3)
        0: c.action = ACT_FREQ;
        1: c.action = ACT_AMPL;
        default: c.action = ACT_PHASE;
      endcase
    end
    case (c.action)
      ACT_FREQ: lim = FREQ_MAX;
      ACT_AMPL: lim = AMPL_MAX;
      default: lim = PHASE_MAX;
    endcase
    case ($urandom_range(0, 9))
      6: c.value = lim;
      7: c.value = ValueW'($urandom());
      8: c.value = lim + ValueW'($urandom_range(1, 1000));
      9: c.value = '0;
      default: c.value = ValueW'($urandom_range(0, lim));
    endcase
    return c;
  endfunction

  task automatic send_cmd(input cmd_t cmd);
    cmd_valid <= 1'b1;
    cmd_data  <= cmd;
    do @(posedge clk); while (cmd_stall);
    predict_frames(cmd);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && allow_gaps) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_cmd(random_cmd());
    end
  endtask

  task automatic write_select(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SEL_ZERO) sel_zero = val;
    else if (idx == CFG_SEL_ONE) sel_one = val;
    @(posedge clk);
  endtask

  // Idle the command side, let the expected beats drain, then settle
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    cmd_valid <= 1'b0;
    while (pending_beats.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_cmd(mk_cmd(ACT_FREQ, 1'b0, '0));
    send_cmd(mk_cmd(ACT_FREQ, 1'b1, 28'd1));
    send_cmd(mk_cmd(ACT_FREQ, 1'b0, FREQ_MAX));
    send_cmd(mk_cmd(ACT_FREQ, 1'b1, FREQ_MAX + 28'd1));
    send_cmd(mk_cmd(ACT_FREQ, 1'b0, '1));
    send_cmd(mk_cmd(ACT_FREQ, 1'b1, 28'd123456789));
    send_cmd(mk_cmd(ACT_AMPL, 1'b0, '0));
    send_cmd(mk_cmd(ACT_AMPL, 1'b1, AMPL_MAX));
    send_cmd(mk_cmd(ACT_AMPL, 1'b0, AMPL_MAX + 28'd1));
    send_cmd(mk_cmd(ACT_AMPL, 1'b1, '1));
    send_cmd(mk_cmd(ACT_AMPL, 1'b0, 28'h2AA));
    send_cmd(mk_cmd(ACT_PHASE, 1'b1, '0));
    send_cmd(mk_cmd(ACT_PHASE, 1'b0, 28'd1));
    send_cmd(mk_cmd(ACT_PHASE, 1'b1, 28'd359));
    send_cmd(mk_cmd(ACT_PHASE, 1'b0, PHASE_MAX));
    send_cmd(mk_cmd(ACT_PHASE, 1'b1, PHASE_MAX + 28'd1));
    send_cmd(mk_cmd(ACT_PHASE, 1'b0, '1));
    send_cmd(mk_cmd(ACT_UNUSED, 1'b0, '0));
    send_cmd(mk_cmd(ACT_UNUSED, 1'b1, '1));
    send_cmd(mk_cmd(ACT_FREQ, 1'b0, 28'd5));
  endtask

  task automatic test_select_sweep();
    logic [ByteW-1:0] z;
    logic [ByteW-1:0] o;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin z = 8'h00; o = 8'hFF; end
        1: begin z = 8'hFF; o = 8'h00; end
        2: begin z = ByteW'($urandom()); o = ByteW'($urandom()); end
        default: begin z = 8'h00; o = 8'h00; end
      endcase
      wait_drained();
      write_select(CFG_SEL_ZERO, z);
      write_select(CFG_SEL_ONE, o);
      send_random(28);
    end
  endtask

  // Writes past the two select registers must leave them untouched
  task automatic test_unmapped_index();
    wait_drained();
    write_select(CFG_SEL_ZERO, ByteW'($urandom()));
    write_select(CFG_SEL_ONE, ByteW'($urandom()));
    write_select(CFG_UNMAPPED_LO, ByteW'($urandom()));
    write_select(CFG_UNMAPPED_HI, ByteW'($urandom()));
    send_random(10);
  endtask

  task automatic test_backpressure();
    -> hold_kick;
    allow_gaps = 1'b0;
    send_random(24);
    allow_gaps = 1'b1;
  endtask

  task automatic test_random_mix();
    send_random(25);
    wait_drained();
    write_select(CFG_SEL_ZERO, ByteW'($urandom()));
    write_select(CFG_SEL_ONE, ByteW'($urandom()));
    send_random(25);
  endtask

  // Long receiver hold-off, counted here so the sender keeps offering commands
  initial forever begin
    @(hold_kick);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 90);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_FLOW: spi_stall <= hold_active;
      RX_LIGHT: spi_stall <= hold_active || ($urandom_range(0, 3) == 0);
      RX_HEAVY: spi_stall <= hold_active || ($urandom_range(0, 3) != 0);
      default: spi_stall <= hold_active || (rx_tick % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && spi_valid && !spi_stall) begin
      if (pending_beats.size() == 0) begin
        flag_failure($sformatf("unexpected beat: byte %02h fe %0b last %0b",
                               spi_data.spi_byte, spi_data.frame_end, spi_data.last));
      end else begin
        want = pending_beats.pop_front();
        if (spi_data.spi_byte !== want.spi_byte || spi_data.frame_end !== want.frame_end ||
            spi_data.last !== want.last) begin
          flag_failure($sformatf(
            "beat mismatch: exp byte %02h fe %0b last %0b, got byte %02h fe %0b last %0b",
            want.spi_byte, want.frame_end, want.last,
            spi_data.spi_byte, spi_data.frame_end, spi_data.last));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_select_sweep();
    test_unmapped_index();
    test_backpressure();
    test_random_mix();
    wait_drained();
    if (pending_beats.size() != 0) begin
      flag_failure($sformatf("%0d expected beats never arrived", pending_beats.size()));
    end
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dccf_pkg.sv
rtl/dds_channel_command_framer.sv
test/dds_channel_command_framer_tb.sv
